[rtl/core/wlsr_pkg.sv]
package wlsr_pkg;

   // default sizes
   localparam int SLOTS_DEF = 8;
   localparam int RING_DEF  = 17;

   // fixed field widths
   localparam int ACT_W  = 3;
   localparam int SLOT_W = 3;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 8;
   localparam int POS_W  = 5;

   localparam logic [BYTE_W-1:0] VERSION_MARK = 8'h81;
   localparam logic [BYTE_W-1:0] ERASED_BYTE  = 8'hFF;
   localparam logic [BYTE_W-1:0] DELAY_RESET  = 8'd51;

   typedef enum logic [ACT_W-1:0] {
      ACT_RESTORE   = 3'd0,
      ACT_GET       = 3'd1,
      ACT_SET       = 3'd2,
      ACT_POLL      = 3'd3,
      ACT_TICK      = 3'd4,
      ACT_RAW_WRITE = 3'd5,
      ACT_RAW_READ  = 3'd6
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RAW_CAP,
      ST_RS_VER,
      ST_RS_SUM,
      ST_RS_SUM_WAIT,
      ST_RS_DECIDE,
      ST_RS_LOAD,
      ST_RS_LOAD_WAIT,
      ST_WR_SETUP,
      ST_WR_BYTE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic take;
      logic clr_step;
      logic raw_cap;
      logic scan_init;
      logic sweep_clr;
      logic sweep_rd;
      logic load;
      logic pos_next;
      logic accept_rec;
      logic wr_setup;
      logic wr_byte;
      logic wr_done;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_restore;
      logic is_raw_read;
      logic poll_write;
      logic ver_ok;
      logic sweep_last;
      logic rec_accept;
      logic rec_stop;
      logic pos_last;
   } dp_status_type;

endpackage

[rtl/core/wlsr_ifs.sv]
interface wlsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [wlsr_pkg::ACT_W-1:0]  action;
   logic [wlsr_pkg::SLOT_W-1:0] slot;
   logic [wlsr_pkg::BYTE_W-1:0] data_value;
   logic [wlsr_pkg::ADDR_W-1:0] store_addr;

   modport source (output valid, action, slot, data_value, store_addr, input ready);
   modport sink   (input valid, action, slot, data_value, store_addr, output ready);
endinterface

interface wlsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wlsr_pkg::BYTE_W-1:0] result_value;
   logic                        found;
   logic                        saved;
   logic                        pending;
   logic [wlsr_pkg::POS_W-1:0]  ring_position;
   logic [wlsr_pkg::BYTE_W-1:0] sequence_res;

   modport source (output valid, result_value, found, saved, pending, ring_position,
                   sequence_res, input ready);
   modport sink   (input valid, result_value, found, saved, pending, ring_position,
                   sequence_res, output ready);
endinterface

[rtl/core/wlsr_controller.sv]
module wlsr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wlsr_pkg::dp_cmd_type    cmd,
   input  wlsr_pkg::dp_status_type st
);
   import wlsr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (st.is_restore)  state_in = ST_RS_VER;
               else if (st.is_raw_read)     state_in = ST_RAW_CAP;
               else if (st.poll_write)      state_in = ST_WR_SETUP;
               else                         state_in = ST_FIN;
            end
         end
         ST_RAW_CAP:     state_in = ST_FIN;
         ST_RS_VER:      state_in = st.ver_ok ? ST_RS_SUM : ST_FIN;
         ST_RS_SUM: begin
            if (st.sweep_last) state_in = ST_RS_SUM_WAIT;
         end
         ST_RS_SUM_WAIT: state_in = ST_RS_DECIDE;
         ST_RS_DECIDE: begin
            priority if (st.rec_accept) state_in = ST_RS_LOAD;
            else if (st.rec_stop)       state_in = ST_FIN;
            else if (st.pos_last)       state_in = ST_FIN;
            else                        state_in = ST_RS_SUM;
         end
         ST_RS_LOAD: begin
            if (st.sweep_last) state_in = ST_RS_LOAD_WAIT;
         end
         ST_RS_LOAD_WAIT: state_in = st.pos_last ? ST_FIN : ST_RS_SUM;
         ST_WR_SETUP:     state_in = ST_WR_BYTE;
         ST_WR_BYTE: begin
            if (st.sweep_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_RAW_CAP: cmd.raw_cap = 1'b1;
         ST_RS_VER:  cmd.scan_init = st.ver_ok;
         ST_RS_SUM:  cmd.sweep_rd = 1'b1;
         ST_RS_SUM_WAIT: ;
         ST_RS_DECIDE: begin
            cmd.sweep_clr  = 1'b1;
            cmd.accept_rec = st.rec_accept;
            cmd.pos_next   = !st.rec_accept && !st.rec_stop && !st.pos_last;
         end
         ST_RS_LOAD: begin
            cmd.sweep_rd = 1'b1;
            cmd.load     = 1'b1;
         end
         ST_RS_LOAD_WAIT: begin
            cmd.pos_next  = !st.pos_last;
            cmd.sweep_clr = !st.pos_last;
         end
         ST_WR_SETUP: cmd.wr_setup = 1'b1;
         ST_WR_BYTE: begin
            cmd.wr_byte = 1'b1;
            cmd.wr_done = st.sweep_last;
         end
         ST_FIN: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/wlsr_datapath.sv]
module wlsr_datapath #(
   parameter int SLOTS        = wlsr_pkg::SLOTS_DEF,
   parameter int RING_ENTRIES = wlsr_pkg::RING_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wlsr_pkg::dp_cmd_type         cmd,
   output wlsr_pkg::dp_status_type      st,
   input  logic [wlsr_pkg::ACT_W-1:0]   req_action,
   input  logic [wlsr_pkg::SLOT_W-1:0]  req_slot,
   input  logic [wlsr_pkg::BYTE_W-1:0]  req_data_value,
   input  logic [wlsr_pkg::ADDR_W-1:0]  req_store_addr,
   input  logic                         csr_wr_en,
   input  logic [wlsr_pkg::BYTE_W-1:0]  csr_wr_data,
   output logic [wlsr_pkg::BYTE_W-1:0]  rsp_result_value,
   output logic                         rsp_found,
   output logic                         rsp_saved,
   output logic                         rsp_pending,
   output logic [wlsr_pkg::POS_W-1:0]   rsp_ring_position,
   output logic [wlsr_pkg::BYTE_W-1:0]  rsp_sequence_res
);
   import wlsr_pkg::*;

   localparam int REC_BYTES   = SLOTS + 2;
   localparam int STORE_BYTES = 1 + RING_ENTRIES * REC_BYTES;
   localparam int MA_W        = $clog2(STORE_BYTES);
   localparam int RB_W        = $clog2(REC_BYTES);
   localparam int SI_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [POS_W-1:0] NO_REC    = POS_W'(RING_ENTRIES);
   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(RING_ENTRIES - 1);
   localparam logic [RB_W-1:0]  LAST_RB   = RB_W'(REC_BYTES - 1);
   localparam logic [MA_W-1:0]  LAST_ADDR = MA_W'(STORE_BYTES - 1);

   // store
   logic [BYTE_W-1:0] store_mem [STORE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              mem_we, rd_en;
   logic [MA_W-1:0]   mem_wa, rd_addr;
   logic [BYTE_W-1:0] mem_wd;

   // control state
   logic [MA_W-1:0]   clr_ff, clr_in;
   logic              dirty_ff, dirty_in;
   logic              armed_ff, armed_in;
   logic [POS_W-1:0]  cur_pos_ff, cur_pos_in;
   logic [BYTE_W-1:0] cur_seq_ff, cur_seq_in;
   logic [BYTE_W-1:0] delay_ff, delay_in;
   logic [BYTE_W-1:0] cfg_ff, cfg_in;
   logic [BYTE_W-1:0] cache_ff [SLOTS];
   logic [BYTE_W-1:0] cache_in [SLOTS];
   logic              rd_vld_ff, rd_vld_in;

   // sequencer payload
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [RB_W-1:0]   rb_ff, rb_in;
   logic [RB_W-1:0]   rd_idx_ff, rd_idx_in;
   logic              load_ff, load_in;
   logic              have_ff, have_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] seq_cand_ff, seq_cand_in;
   logic              raw_ok_ff, raw_ok_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic              saved_ff, saved_in;

   // result register
   logic [BYTE_W-1:0] out_value_ff;
   logic              out_found_ff, out_saved_ff, out_pending_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic [BYTE_W-1:0] out_seq_ff;

   logic              slot_ok, addr_ok;
   logic [SI_W-1:0]   cache_idx;
   logic [BYTE_W-1:0] cache_rd;
   logic [POS_W-1:0]  rec_pos;
   logic [MA_W-1:0]   rec_base, sweep_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] step;
   logic              rec_valid;

   assign slot_ok   = 32'(req_slot) < SLOTS;
   assign addr_ok   = 32'(req_store_addr) < STORE_BYTES;
   assign cache_idx = cmd.take ? SI_W'(req_slot) : SI_W'(rb_ff - RB_W'(1));
   assign cache_rd  = cache_ff[cache_idx];

   // record base is 1 + position * record length
   assign rec_pos    = cmd.wr_byte ? cur_pos_ff : pos_ff;
   assign rec_base   = MA_W'(32'(rec_pos) * REC_BYTES + 1);
   assign sweep_addr = MA_W'(rec_base + MA_W'(rb_ff));

   always_comb begin
      priority if (rb_ff == '0)   wr_data = cur_seq_ff;
      else if (rb_ff == LAST_RB)  wr_data = 8'd0 - sum_ff;
      else                        wr_data = cache_rd;
   end

   // store ports
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = ERASED_BYTE;
      priority if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
      end else if (cmd.take && req_action == ACT_RAW_WRITE && addr_ok) begin
         mem_we = 1'b1;
         mem_wa = MA_W'(req_store_addr);
         mem_wd = req_data_value;
      end else if (cmd.wr_setup && cur_pos_ff >= NO_REC) begin
         mem_we = 1'b1;
         mem_wd = VERSION_MARK;
      end else if (cmd.wr_byte) begin
         mem_we = 1'b1;
         mem_wa = sweep_addr;
         mem_wd = wr_data;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      priority if (cmd.take && req_action == ACT_RESTORE) begin
         rd_en = 1'b1;
      end else if (cmd.take && req_action == ACT_RAW_READ && addr_ok) begin
         rd_en   = 1'b1;
         rd_addr = MA_W'(req_store_addr);
      end else if (cmd.sweep_rd) begin
         rd_en   = 1'b1;
         rd_addr = sweep_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_wa] <= mem_wd;
      if (rd_en)  rd_data_ff <= store_mem[rd_addr];
   end

   // next values
   always_comb begin
      clr_in      = clr_ff;
      dirty_in    = dirty_ff;
      armed_in    = armed_ff;
      cur_pos_in  = cur_pos_ff;
      cur_seq_in  = cur_seq_ff;
      delay_in    = delay_ff;
      cfg_in      = cfg_ff;
      cache_in    = cache_ff;
      pos_in      = pos_ff;
      rb_in       = rb_ff;
      have_in     = have_ff;
      sum_in      = sum_ff;
      seq_cand_in = seq_cand_ff;
      raw_ok_in   = raw_ok_ff;
      value_in    = value_ff;
      saved_in    = saved_ff;
      rd_vld_in   = cmd.sweep_rd;
      rd_idx_in   = rb_ff;
      load_in     = cmd.load;

      if (csr_wr_en) cfg_in = csr_wr_data;
      if (cmd.clr_step) clr_in = clr_ff + MA_W'(1);

      if (cmd.take) begin
         value_in = '0;
         saved_in = 1'b0;
         unique case (req_action)
            ACT_RESTORE: begin
               dirty_in   = 1'b0;
               armed_in   = 1'b0;
               cur_pos_in = NO_REC;
               cur_seq_in = '0;
            end
            ACT_GET: begin
               if (cur_pos_ff != NO_REC && slot_ok) value_in = cache_rd;
            end
            ACT_SET: begin
               if (slot_ok && cache_rd != req_data_value) begin
                  cache_in[cache_idx] = req_data_value;
                  dirty_in = 1'b1;
                  armed_in = 1'b0;
               end
            end
            ACT_POLL: begin
               if (dirty_ff && !armed_ff) begin
                  delay_in = cfg_ff;
                  armed_in = 1'b1;
               end
            end
            ACT_TICK: begin
               if (delay_ff != '0) delay_in = delay_ff - 8'd1;
            end
            ACT_RAW_WRITE: ;
            ACT_RAW_READ: raw_ok_in = addr_ok;
            default: ;
         endcase
      end

      if (cmd.raw_cap && raw_ok_ff) value_in = rd_data_ff;

      // returning store bytes of a sweep
      if (rd_vld_ff) begin
         sum_in = sum_ff + rd_data_ff;
         if (rd_idx_ff == '0) seq_cand_in = rd_data_ff;
         if (load_ff && rd_idx_ff != '0 && rd_idx_ff != LAST_RB)
            cache_in[SI_W'(rd_idx_ff - RB_W'(1))] = rd_data_ff;
      end

      if (cmd.sweep_rd) rb_in = rb_ff + RB_W'(1);
      if (cmd.scan_init) begin
         pos_in  = '0;
         have_in = 1'b0;
      end
      if (cmd.scan_init || cmd.sweep_clr) begin
         rb_in  = '0;
         sum_in = '0;
      end
      if (cmd.pos_next) pos_in = pos_ff + POS_W'(1);
      if (cmd.accept_rec) begin
         cur_pos_in = pos_ff;
         cur_seq_in = seq_cand_ff;
         have_in    = 1'b1;
      end

      if (cmd.wr_setup) begin
         if (cur_pos_ff >= NO_REC || cur_pos_ff == LAST_POS) cur_pos_in = '0;
         else                                                cur_pos_in = cur_pos_ff + POS_W'(1);
         cur_seq_in = cur_seq_ff + 8'd1;
         rb_in      = '0;
         sum_in     = '0;
      end
      if (cmd.wr_byte) begin
         sum_in = sum_ff + wr_data;
         rb_in  = rb_ff + RB_W'(1);
      end
      if (cmd.wr_done) begin
         dirty_in = 1'b0;
         armed_in = 1'b0;
         saved_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         dirty_ff   <= 1'b0;
         armed_ff   <= 1'b0;
         cur_pos_ff <= NO_REC;
         cur_seq_ff <= '0;
         delay_ff   <= '0;
         cfg_ff     <= DELAY_RESET;
         cache_ff   <= '{default: '0};
         rd_vld_ff  <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         dirty_ff   <= dirty_in;
         armed_ff   <= armed_in;
         cur_pos_ff <= cur_pos_in;
         cur_seq_ff <= cur_seq_in;
         delay_ff   <= delay_in;
         cfg_ff     <= cfg_in;
         cache_ff   <= cache_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rb_ff       <= rb_in;
      rd_idx_ff   <= rd_idx_in;
      load_ff     <= load_in;
      have_ff     <= have_in;
      sum_ff      <= sum_in;
      seq_cand_ff <= seq_cand_in;
      raw_ok_ff   <= raw_ok_in;
      value_ff    <= value_in;
      saved_ff    <= saved_in;
      if (cmd.out_load) begin
         out_value_ff   <= value_ff;
         out_found_ff   <= cur_pos_ff != NO_REC;
         out_saved_ff   <= saved_ff;
         out_pending_ff <= armed_ff;
         out_pos_ff     <= cur_pos_ff;
         out_seq_ff     <= cur_seq_ff;
      end
   end

   // status
   assign step      = seq_cand_ff - cur_seq_ff;
   assign rec_valid = sum_ff == '0;

   always_comb begin
      st             = '0;
      st.clr_last    = clr_ff == LAST_ADDR;
      st.is_restore  = req_action == ACT_RESTORE;
      st.is_raw_read = req_action == ACT_RAW_READ;
      st.poll_write  = req_action == ACT_POLL && dirty_ff && armed_ff && delay_ff == '0;
      st.ver_ok      = rd_data_ff == VERSION_MARK;
      st.sweep_last  = rb_ff == LAST_RB;
      st.rec_accept  = rec_valid && (!have_ff || 32'(step) < RING_ENTRIES);
      st.rec_stop    = rec_valid && have_ff && !(32'(step) < RING_ENTRIES);
      st.pos_last    = pos_ff == LAST_POS;
   end

   assign rsp_result_value  = out_value_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_saved         = out_saved_ff;
   assign rsp_pending       = out_pending_ff;
   assign rsp_ring_position = out_pos_ff;
   assign rsp_sequence_res  = out_seq_ff;

endmodule

[rtl/core/wear_leveled_settings_ring.sv]
// Settings cache with a wear-leveled ring of records in a byte-wide store
// (version byte at address 0, then RING_ENTRIES records of sequence byte,
// SLOTS setting bytes and a checksum byte). Items are handled one at a time
// and each answers with exactly one item on rsp_if. The store has one write
// port and one read port, each moving one byte per cycle, which sets the
// cost of the long actions: a save poll that writes a record sweeps out
// each record byte in turn, and a restore reads the version byte, sweeps
// each scanned record for its checksum and sweeps it again if it is taken
// into the cache. A result that is not taken yet holds back only the end of
// the next item, not its acceptance. After reset a clearing pass erases the
// store to 0xFF, one byte per cycle; req_if.ready stays low during it, while
// csr writes are taken at any time.
module wear_leveled_settings_ring #(
   parameter int SLOTS        = wlsr_pkg::SLOTS_DEF,
   parameter int RING_ENTRIES = wlsr_pkg::RING_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   wlsr_req_if.sink                    req_if,
   wlsr_rsp_if.source                  rsp_if,
   input  logic                        csr_wr_en,
   input  logic [wlsr_pkg::BYTE_W-1:0] csr_wr_data
);
   import wlsr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   // sequencer: clearing pass, dispatch, restore scan, record write, result hand-off
   wlsr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .st        (st)
   );

   // store, cache, save timer, scan counters and result register
   wlsr_datapath #(
      .SLOTS        (SLOTS),
      .RING_ENTRIES (RING_ENTRIES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_action        (req_if.action),
      .req_slot          (req_if.slot),
      .req_data_value    (req_if.data_value),
      .req_store_addr    (req_if.store_addr),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_result_value  (rsp_if.result_value),
      .rsp_found         (rsp_if.found),
      .rsp_saved         (rsp_if.saved),
      .rsp_pending       (rsp_if.pending),
      .rsp_ring_position (rsp_if.ring_position),
      .rsp_sequence_res  (rsp_if.sequence_res)
   );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

import wlsr_pkg::*;

localparam int REC_LEN   = SLOTS_DEF + 2;
localparam int STORE_LEN = 1 + RING_DEF * REC_LEN;

typedef struct packed {
   logic [BYTE_W-1:0] value;
   logic              found;
   logic              saved;
   logic              pending;
   logic [POS_W-1:0]  position;
   logic [BYTE_W-1:0] seq_no;
} ring_answer_type;

// mirror of the settings cache and the record store, with the answers still owed
class settings_ring_mirror;
   logic [BYTE_W-1:0] store_image [STORE_LEN];
   logic [BYTE_W-1:0] cache_image [SLOTS_DEF];
   bit                dirty;
   bit                armed;
   logic [POS_W-1:0]  position;
   logic [BYTE_W-1:0] seq_no;
   logic [BYTE_W-1:0] countdown;
   logic [BYTE_W-1:0] delay_setting;
   ring_answer_type   awaited_answers [$];
   int                mismatches;
   int                records_written;
   int                restores_found;
   int                answers_checked;

   function new();
      foreach (store_image[i]) store_image[i] = ERASED_BYTE;
      foreach (cache_image[i]) cache_image[i] = '0;
      dirty           = 1'b0;
      armed           = 1'b0;
      position        = POS_W'(RING_DEF);
      seq_no          = '0;
      countdown       = '0;
      delay_setting   = DELAY_RESET;
      mismatches      = 0;
      records_written = 0;
      restores_found  = 0;
      answers_checked = 0;
   endfunction

   function bit record_ok(int p);
      int                base = 1 + p * REC_LEN;
      logic [BYTE_W-1:0] sum  = '0;
      for (int k = 0; k < REC_LEN; k++) sum += store_image[base + k];
      return sum == '0;
   endfunction

   function void take_record(int p);
      int base = 1 + p * REC_LEN;
      position = POS_W'(p);
      seq_no   = store_image[base];
      for (int k = 0; k < SLOTS_DEF; k++) cache_image[k] = store_image[base + 1 + k];
   endfunction

   // first valid record, then follow records whose sequence moves on by less than the ring
   function void restore_scan();
      int                p;
      bit                have;
      logic [BYTE_W-1:0] step;
      dirty    = 1'b0;
      armed    = 1'b0;
      position = POS_W'(RING_DEF);
      seq_no   = '0;
      have     = 1'b0;
      if (store_image[0] != VERSION_MARK) return;
      for (p = 0; p < RING_DEF; p++) begin
         if (record_ok(p)) begin
            take_record(p);
            have = 1'b1;
            break;
         end
      end
      if (!have) return;
      for (; p < RING_DEF; p++) begin
         if (!record_ok(p)) continue;
         step = store_image[1 + p * REC_LEN] - seq_no;
         if (step < RING_DEF) take_record(p);
         else break;
      end
   endfunction

   function void write_record();
      int                base;
      logic [BYTE_W-1:0] sum;
      if (position >= RING_DEF) begin
         store_image[0] = VERSION_MARK;
         position       = '0;
      end else if (position + 1 >= RING_DEF) begin
         position = '0;
      end else begin
         position = position + 1'b1;
      end
      seq_no = seq_no + 1'b1;
      base   = 1 + int'(position) * REC_LEN;
      store_image[base] = seq_no;
      sum = seq_no;
      for (int k = 0; k < SLOTS_DEF; k++) begin
         store_image[base + 1 + k] = cache_image[k];
         sum += cache_image[k];
      end
      store_image[base + 1 + SLOTS_DEF] = -sum;
   endfunction

   function void note_request(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] sl,
                              logic [BYTE_W-1:0] dv, logic [ADDR_W-1:0] ad);
      ring_answer_type   ans;
      logic [BYTE_W-1:0] val;
      bit                wrote;
      val   = '0;
      wrote = 1'b0;
      case (act)
         ACT_RESTORE: begin
            restore_scan();
            if (position != RING_DEF) restores_found++;
         end
         ACT_GET: begin
            if (position != RING_DEF && sl < SLOTS_DEF) val = cache_image[sl];
         end
         ACT_SET: begin
            if (sl < SLOTS_DEF && cache_image[sl] != dv) begin
               cache_image[sl] = dv;
               dirty = 1'b1;
               armed = 1'b0;
            end
         end
         ACT_POLL: begin
            if (dirty) begin
               if (!armed) begin
                  countdown = delay_setting;
                  armed     = 1'b1;
               end else if (countdown == '0) begin
                  write_record();
                  dirty = 1'b0;
                  armed = 1'b0;
                  wrote = 1'b1;
                  records_written++;
               end
            end
         end
         ACT_TICK: begin
            if (countdown != '0) countdown = countdown - 1'b1;
         end
         ACT_RAW_WRITE: begin
            if (ad < STORE_LEN) store_image[ad] = dv;
         end
         ACT_RAW_READ: begin
            if (ad < STORE_LEN) val = store_image[ad];
         end
         default: ;
      endcase
      ans.value    = val;
      ans.found    = (position != RING_DEF);
      ans.saved    = wrote;
      ans.pending  = armed;
      ans.position = position;
      ans.seq_no   = seq_no;
      awaited_answers.push_back(ans);
   endfunction

   task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   task check_result(ring_answer_type got);
      ring_answer_type want;
      answers_checked++;
      if (awaited_answers.size() == 0) begin
         report_mismatch($sformatf("answer %0d arrived with none expected", answers_checked));
         return;
      end
      want = awaited_answers.pop_front();
      if (got.value !== want.value)
         report_mismatch($sformatf("answer %0d result_value %0h, expected %0h",
                                   answers_checked, got.value, want.value));
      if (got.found !== want.found)
         report_mismatch($sformatf("answer %0d found %0b, expected %0b",
                                   answers_checked, got.found, want.found));
      if (got.saved !== want.saved)
         report_mismatch($sformatf("answer %0d saved %0b, expected %0b",
                                   answers_checked, got.saved, want.saved));
      if (got.pending !== want.pending)
         report_mismatch($sformatf("answer %0d pending %0b, expected %0b",
                                   answers_checked, got.pending, want.pending));
      if (got.position !== want.position)
         report_mismatch($sformatf("answer %0d ring_position %0d, expected %0d",
                                   answers_checked, got.position, want.position));
      if (got.seq_no !== want.seq_no)
         report_mismatch($sformatf("answer %0d sequence_res %0h, expected %0h",
                                   answers_checked, got.seq_no, want.seq_no));
   endtask
endclass

module testbench;

   // limit on the whole run, set well above the slowest legal run (every item a full
   // restore scan plus stalls)
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
   localparam int PHASES = 5;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   wlsr_req_if req_bus ();
   wlsr_rsp_if rsp_bus ();

   settings_ring_mirror mirror;

   bit     no_idle;
   int     items_sent;
   longint cycle_count = 0;

   wear_leveled_settings_ring dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("wear_leveled_settings_ring regression: fail");
         $finish;
      end
   end

   // result side: ready drops about one cycle in ten, except in the steady phase
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 10);
      end
   end

   // every accepted result goes against the oldest expectation
   always @(posedge clock) begin
      ring_answer_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         got.value    = rsp_bus.result_value;
         got.found    = rsp_bus.found;
         got.saved    = rsp_bus.saved;
         got.pending  = rsp_bus.pending;
         got.position = rsp_bus.ring_position;
         got.seq_no   = rsp_bus.sequence_res;
         mirror.check_result(got);
      end
   end

   // one item on the request side; valid stays up between back-to-back items
   task automatic send_item(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] sl,
                            logic [BYTE_W-1:0] dv, logic [ADDR_W-1:0] ad);
      while (!no_idle && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.slot       <= sl;
      req_bus.data_value <= dv;
      req_bus.store_addr <= ad;
      do @(posedge clock); while (!req_bus.ready);
      mirror.note_request(act, sl, dv, ad);
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every expected answer is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (mirror.awaited_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_delay(logic [BYTE_W-1:0] ticks);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mirror.delay_setting = ticks;
   endtask

   task automatic directed_items();
      // empty store: get without a record, reads at both ends and past the end
      send_item(ACT_GET, 3'd7, 8'h00, 8'h00);
      send_item(ACT_RAW_READ, 3'd0, 8'h00, 8'd0);
      send_item(ACT_RAW_READ, 3'd0, 8'h00, 8'd170);
      send_item(ACT_RAW_READ, 3'd0, 8'h00, 8'd171);
      send_item(ACT_RAW_WRITE, 3'd0, 8'hFF, 8'hFF);   // out of range, dropped
      send_item(ACT_RAW_READ, 3'd0, 8'h00, 8'hFF);
      send_item(ACT_RESTORE, 3'd0, 8'h00, 8'h00);     // erased version byte
      // sets, unchanged sets, and a set that disarms a pending save
      send_item(ACT_SET, 3'd0, 8'hAA, 8'h00);
      send_item(ACT_SET, 3'd0, 8'hAA, 8'h00);
      send_item(ACT_SET, 3'd7, 8'h00, 8'h00);
      send_item(ACT_POLL, 3'd0, 8'h00, 8'h00);
      send_item(ACT_SET, 3'd7, 8'hFF, 8'h00);
      send_item(ACT_POLL, 3'd0, 8'h00, 8'h00);
      send_item(ACT_TICK, 3'd0, 8'h00, 8'h00);        // counter already at zero
      send_item(ACT_POLL, 3'd0, 8'h00, 8'h00);        // zero delay: first record written
      send_item(ACT_POLL, 3'd0, 8'h00, 8'h00);        // clean, nothing to do
      send_item(ACT_GET, 3'd7, 8'h00, 8'h00);
      send_item(ACT_RAW_READ, 3'd0, 8'h00, 8'd0);
      send_item(ACT_RESTORE, 3'd0, 8'h00, 8'h00);
      // break record 0, then the version byte
      send_item(ACT_RAW_WRITE, 3'd0, 8'h00, 8'd1);
      send_item(ACT_RESTORE, 3'd0, 8'h00, 8'h00);
      send_item(ACT_GET, 3'd0, 8'h00, 8'h00);
      send_item(ACT_RAW_WRITE, 3'd0, 8'h00, 8'd0);
      send_item(ACT_RESTORE, 3'd0, 8'h00, 8'h00);
      send_item(ACT_UNUSED, 3'd7, 8'hFF, 8'hFF);
   endtask

   // change some settings, arm, tick around the delay and poll for the write
   task automatic save_burst(int ticks_cfg);
      int                n;
      int                t;
      logic [SLOT_W-1:0] sl;
      logic [BYTE_W-1:0] dv;
      n = $urandom_range(1, 3);
      repeat (n) begin
         sl = SLOT_W'($urandom);
         dv = ($urandom_range(0, 3) == 0) ? mirror.cache_image[sl] : BYTE_W'($urandom);
         send_item(ACT_SET, sl, dv, ADDR_W'($urandom));
      end
      send_item(ACT_POLL, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
      if (ticks_cfg == 0)
         t = $urandom_range(0, 2);
      else if (ticks_cfg <= 8 || (ticks_cfg <= 60 && $urandom_range(0, 2) == 0))
         t = ticks_cfg - 1 + $urandom_range(0, 3);
      else
         t = $urandom_range(0, 6);
      repeat (t) send_item(ACT_TICK, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
      send_item(ACT_POLL, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
      if ($urandom_range(0, 1) == 0)
         send_item(ACT_POLL, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
      if ($urandom_range(0, 2) == 0)
         send_item(ACT_GET, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
   endtask

   // hand-built record through raw writes, often near the current sequence, then a restore
   task automatic forge_record();
      int                p;
      logic [BYTE_W-1:0] rec [REC_LEN];
      logic [BYTE_W-1:0] sum;
      if ($urandom_range(0, 1) == 0)
         p = (mirror.position >= RING_DEF) ? 0 : (int'(mirror.position) + 1) % RING_DEF;
      else
         p = $urandom_range(0, RING_DEF - 1);
      rec[0] = ($urandom_range(0, 1) == 0) ? mirror.seq_no + BYTE_W'($urandom_range(0, 20))
                                          : BYTE_W'($urandom);
      sum = rec[0];
      for (int k = 1; k <= SLOTS_DEF; k++) begin
         rec[k] = BYTE_W'($urandom);
         sum += rec[k];
      end
      rec[REC_LEN-1] = -sum;
      // some records go in with a bad checksum
      if ($urandom_range(0, 4) == 0)
         rec[$urandom_range(0, REC_LEN - 1)] ^= BYTE_W'($urandom_range(1, 255));
      if ($urandom_range(0, 2) == 0)
         send_item(ACT_RAW_WRITE, SLOT_W'($urandom),
                   ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom) : VERSION_MARK, 8'd0);
      for (int k = 0; k < REC_LEN; k++)
         send_item(ACT_RAW_WRITE, SLOT_W'($urandom), rec[k], ADDR_W'(1 + p * REC_LEN + k));
      if ($urandom_range(0, 3) != 0)
         send_item(ACT_RESTORE, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
   endtask

   task automatic random_items(int ticks_cfg);
      int               r;
      logic [ADDR_W-1:0] ad;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         save_burst(ticks_cfg);
      end else if (r < 58) begin
         forge_record();
      end else if (r < 64) begin
         send_item(ACT_RESTORE, SLOT_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom));
      end else begin
         // lone item of any code, addresses mostly inside the store
         ad = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                          : ADDR_W'($urandom_range(0, STORE_LEN - 1));
         send_item(ACT_W'($urandom_range(0, 7)), SLOT_W'($urandom), BYTE_W'($urandom), ad);
      end
   endtask

   initial begin
      int                phase_ticks [PHASES];
      int                phase_items [PHASES];
      int                goal;
      phase_ticks = '{0, 3, 1, 255, 51};
      phase_items = '{130, 130, 110, 60, 95};
      req_bus.valid      = 1'b0;
      req_bus.action     = '0;
      req_bus.slot       = '0;
      req_bus.data_value = '0;
      req_bus.store_addr = '0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      no_idle            = 1'b0;
      items_sent         = 0;
      mirror             = new();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero delay first, so the directed part sees the next-poll write
      write_delay(8'd0);
      directed_items();

      // the third phase runs with no idling on either side
      for (int ph = 0; ph < PHASES; ph++) begin
         write_delay(BYTE_W'(phase_ticks[ph]));
         no_idle = (ph == 2);
         goal    = items_sent + phase_items[ph];
         while (items_sent < goal) random_items(phase_ticks[ph]);
      end

      drain();
      repeat (20) @(negedge clock);

      $display("covered %0d items at save delays 0, 3, 1, 255 and 51", items_sent);
      $display("%0d records written by save polls, %0d restores found a record",
               mirror.records_written, mirror.restores_found);
      if (mirror.mismatches == 0 && mirror.awaited_answers.size() == 0) begin
         $display("wear_leveled_settings_ring regression: pass");
      end else begin
         $display("%0d mismatches, %0d answers never arrived",
                  mirror.mismatches, mirror.awaited_answers.size());
         $display("wear_leveled_settings_ring regression: fail");
      end
      $finish;
   end

endmodule
